// ===== sv/sha_pkg.sv =====
// shared types and constants of the sha-256 engine
`timescale 1ns / 1ps
package sha_pkg;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   typedef logic [255:0] hash_type;

   localparam hash_type HASH_INIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

endpackage

// ===== sv/sha_fifo.sv =====
// short item queue between the front and the back of the engine
`timescale 1ns / 1ps
module sha_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sha_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output sha_pkg::req_type pop_data,
   output logic             empty
);
   import sha_pkg::*;

   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wp_in = ~wp_ff;
      end
      if (pop && !empty) begin
         rp_in = ~rp_ff;
      end
      cnt_in = cnt_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ===== sv/sha_back.sv =====
// block builder, padding, compression rounds and digest output
`timescale 1ns / 1ps
module sha_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  sha_pkg::req_type item,
   output logic             item_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [511:0] blk_ff, blk_in;      // message schedule window, w[t] at top
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bytes_ff, bytes_in;
   hash_type     hash_ff, hash_in;
   hash_type     work_ff, work_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         fin_ff, fin_in;      // compressing the final block
   logic         extra_ff, extra_in;  // another padding block follows
   logic [2:0]   widx_ff, widx_in;

   logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14, s0, s1, t1, t2, wn;
   logic [63:0] bits;

   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      w0  = blk_ff[511:480];
      w1  = blk_ff[479:448];
      w9  = blk_ff[223:192];
      w14 = blk_ff[63:32];
      s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      wn  = s1 + w9 + s0 + w0;
      t1  = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + round_const(rnd_ff) + w0;
      t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));
      bits = {bytes_ff[60:0], 3'b000};
   end

   // every item leaves the queue when idle takes it
   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = '{digest_word: hash_ff[255:224], word_index: widx_ff,
                        last: (widx_ff == 3'd7)};

   // sequencer
   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      extra_in = extra_ff;
      widx_in  = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.op == OP_ABSORB) begin
                  blk_in[511 - 8 * fill_ff -: 8] = item.data_byte;
                  fill_in  = fill_ff + 6'd1;
                  bytes_in = bytes_ff + 64'd1;
                  if (fill_ff == 6'd63) begin
                     work_in  = hash_ff;
                     rnd_in   = 6'd0;
                     fin_in   = 1'b0;
                     state_in = ST_ROUND;
                  end
               end else begin
                  blk_in[511 - 8 * fill_ff -: 8] = 8'h80;
                  fill_in  = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     // marker fills the block, length goes in a second one
                     work_in  = hash_ff;
                     rnd_in   = 6'd0;
                     fin_in   = 1'b0;
                     extra_in = 1'b1;
                     state_in = ST_ROUND;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            // zero fill one byte a cycle, then length and compress
            if (fill_ff == 6'd56 && !extra_ff) begin
               blk_in[63:0] = bits;
               work_in  = hash_ff;
               rnd_in   = 6'd0;
               fin_in   = 1'b1;
               state_in = ST_ROUND;
            end else begin
               blk_in[511 - 8 * fill_ff -: 8] = 8'h00;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  work_in  = hash_ff;
                  rnd_in   = 6'd0;
                  fin_in   = 1'b0;
                  extra_in = 1'b1;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            work_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            blk_in  = {blk_ff[479:0], wn};
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[32 * i +: 32] = hash_ff[32 * i +: 32] + work_ff[32 * i +: 32];
            end
            widx_in = 3'd0;
            if (fin_ff) begin
               state_in = ST_OUT;
            end else if (extra_ff) begin
               extra_in = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               hash_in = {hash_ff[223:0], hash_ff[255:224]};
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  hash_in  = HASH_INIT;
                  fill_in  = 6'd0;
                  bytes_in = 64'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= 6'd0;
         bytes_ff <= 64'd0;
         hash_ff  <= HASH_INIT;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         hash_ff  <= hash_in;
         extra_ff <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
      rnd_ff  <= rnd_in;
      fin_ff  <= fin_in;
      widx_ff <= widx_in;
   end
endmodule

// ===== sv/sha256_hash_engine_core.sv =====
// top level of the byte-serial sha-256 engine
`timescale 1ns / 1ps
// Byte-serial SHA-256. Items enter a two-entry queue; the back end takes an
// absorb item and, on the 64th byte of a block, runs the 64 compression
// rounds at one round per cycle, then the final add. A finish item leaves the
// queue when the back end starts it, pads one byte per cycle, compresses one
// or two blocks, then presents the eight digest words (index 0 first, last
// set on index 7) one per accepted cycle and returns to the initial hash
// state. Further items may wait in the queue meanwhile.
module sha256_hash_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   req_type q_data;
   logic    q_full, q_empty, b_pop;

   assign req_ready = !q_full;

   // front queue
   sha_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (req_data),
      .full      (q_full),
      .pop       (b_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // back end
   sha_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!q_empty),
      .item       (q_data),
      .item_pop   (b_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );
endmodule

// ===== tb/sha256_checker.sv =====
// checker for the sha-256 engine: predicts digests and compares result items
`timescale 1ns / 1ps
module sha256_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sha_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_words
);
   import sha_pkg::*;

   logic [31:0] k_tab [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   logic [31:0] iv_tab [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0] chain [8];
   logic [7:0]  blk_buf [64];
   logic [5:0]  fill_cnt;
   logic [63:0] msg_len;
   rsp_type     digest_q [$];

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // one compression of blk_buf into chain
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2, e, a;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      r = chain;
      for (int i = 0; i < 64; i++) begin
         e = r[4];
         a = r[0];
         t1 = r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & r[5]) ^ (~e & r[6]))
            + k_tab[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = e; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = a; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
   endtask

   task automatic clear_state();
      chain = iv_tab;
      fill_cnt = '0;
      msg_len = '0;
   endtask

   // absorb a byte or pad the message and queue its digest
   task automatic absorb_or_finish(input req_type it);
      logic [63:0] bit_len;
      int pos;
      rsp_type w;
      if (it.op == OP_ABSORB) begin
         blk_buf[fill_cnt] = it.data_byte;
         msg_len++;
         fill_cnt++;
         if (fill_cnt == 0) compress_block();
      end else begin
         bit_len = msg_len << 3;
         pos = fill_cnt;
         blk_buf[pos] = 8'h80;
         pos++;
         if (pos > 56) begin
            while (pos < 64) blk_buf[pos++] = 8'h00;
            compress_block();
            pos = 0;
         end
         while (pos < 56) blk_buf[pos++] = 8'h00;
         for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            w.digest_word = chain[i];
            w.word_index = 3'(i);
            w.last = (i == 7);
            digest_q.push_back(w);
         end
         clear_state();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // watch both channels
   always @(posedge clock) begin
      rsp_type exp_w;
      if (reset) begin
         clear_state();
         digest_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_data.digest_word, 32'd0);
            end else begin
               exp_w = digest_q.pop_front();
               if (rsp_data.digest_word !== exp_w.digest_word)
                  report_mismatch("digest_word", rsp_data.digest_word, exp_w.digest_word);
               if (rsp_data.word_index !== exp_w.word_index)
                  report_mismatch("word_index", {29'd0, rsp_data.word_index},
                                  {29'd0, exp_w.word_index});
               if (rsp_data.last !== exp_w.last)
                  report_mismatch("last", {31'd0, rsp_data.last}, {31'd0, exp_w.last});
            end
         end
         if (req_valid && req_ready) absorb_or_finish(req_data);
      end
      pending_words = digest_q.size();
   end
endmodule

// ===== tb/tb.sv =====
// testbench top for the sha-256 engine: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
   import sha_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_words;
   int      cycle_cnt = 0;
   int      hold_cycles = 0;
   bit      stim_done = 0;

   localparam int CYCLE_LIMIT = 400000;

   sha256_hash_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

   sha256_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_words(pending_words));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2);
   endfunction

   // drive one item and wait for its acceptance
   task automatic send_item(input logic op, input logic [7:0] b, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      repeat (g) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= '{op: op, data_byte: b};
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic send_message(input int len, input bit fixed, input logic [7:0] fill,
                               input bit gaps);
      for (int i = 0; i < len; i++)
         send_item(OP_ABSORB, fixed ? fill : 8'($urandom), gaps);
      send_item(OP_FINISH, 8'($urandom), gaps);
   endtask

   // receiver: random stalls, plus one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (stim_done) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 9) < 7);
      end
   end

   // run-length limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // long hold-off on an empty-message digest while bytes keep coming
      hold_cycles <= 300;
      send_item(OP_FINISH, 8'hff, 0);
      // crosses a block and finishes with the marker on the last byte
      send_message(127, 0, 8'h00, 1);
      // sender waits until every digest word has arrived
      @(posedge clock);
      wait (pending_words == 0);
      send_message(1, 1, 8'hff, 0);
      // back-to-back finishes
      for (int m = 0; m < 2; m++) send_item(OP_FINISH, 8'($urandom), 0);

      stim_done = 1;
      @(posedge clock);
      wait (pending_words == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
